// ===== hdl/bag_pkg.sv =====
// bag_pkg: shared types, field widths, register codes and lookup functions
// for the block average to glyph level block
// no dependencies
package bag_pkg;

  // configuration register widths and codes
  localparam int BW_W   = 7;
  localparam int FW_W   = 13;
  localparam int CFG_DW = 13;
  localparam int CFG_AW = 2;

  localparam logic [CFG_AW-1:0] REG_BLOCK_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_BLOCK_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd3;

  localparam logic [BW_W-1:0] BLOCK_WIDTH_RST  = 7'd8;
  localparam logic [BW_W-1:0] BLOCK_HEIGHT_RST = 7'd16;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FW_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // largest value a register can hold
  localparam int BW_REG_MAX = (1 << BW_W) - 1;
  localparam int FW_REG_MAX = (1 << FW_W) - 1;

  // accumulator widths
  localparam int RUN_W = 14;
  localparam int TOT_W = 20;

  // shared divider
  localparam int DIV_NW = TOT_W;
  localparam int DIV_DW = 2 * BW_W;

  localparam int AVG_MAX = 255;
  localparam int LEVELS  = 13;

  typedef struct packed {
    logic [7:0] gray;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  average;
    logic [3:0]  level;
    logic [6:0]  glyph;
    logic [9:0]  block_column;
    logic [11:0] block_line;
    logic        line_end;
    logic        frame_end;
  } out_item_t;

  // floor(avg * 12 / 255) by comparison against the twelve thresholds
  function automatic logic [3:0] level_of(input logic [7:0] avg);
    logic [11:0] prod;
    logic [3:0]  lvl;
    prod = 12'(avg) * 12'd12;
    lvl  = 4'd0;
    for (int k = 1; k < LEVELS; k++) begin
      if (prod >= 12'(AVG_MAX * k)) lvl = lvl + 4'd1;
    end
    return lvl;
  endfunction

  // character ramp " .,-~:;=!*#$@"
  function automatic logic [6:0] glyph_of(input logic [3:0] lvl);
    logic [6:0] g;
    case (lvl)
      4'd0:    g = 7'h20;
      4'd1:    g = 7'h2e;
      4'd2:    g = 7'h2c;
      4'd3:    g = 7'h2d;
      4'd4:    g = 7'h7e;
      4'd5:    g = 7'h3a;
      4'd6:    g = 7'h3b;
      4'd7:    g = 7'h3d;
      4'd8:    g = 7'h21;
      4'd9:    g = 7'h2a;
      4'd10:   g = 7'h23;
      4'd11:   g = 7'h24;
      4'd12:   g = 7'h40;
      default: g = 7'h20;
    endcase
    return g;
  endfunction

endpackage

// ===== hdl/bag_div.sv =====
// bag_div: restoring divider, one quotient bit per cycle
// depends on bag_pkg for operand widths
module bag_div import bag_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              fits;

  always_comb begin
    trial = {rem, quo[DIV_NW-1]};
    diff  = trial - {1'b0, den};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_NW-2:0], fits};
      rem <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end
  end

  assign quotient = quo;

endmodule

// ===== hdl/bag_line_store.sv =====
// bag_line_store: line store of per-block column sums, one write and one
// registered read port; depends on bag_pkg for the entry width
module bag_line_store import bag_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [TOT_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [TOT_W-1:0] wr_data
);

  logic [TOT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/block_average_to_glyph_level.sv =====
// block_average_to_glyph_level: top level, position counters, control and
// output register; depends on bag_pkg, bag_div and bag_line_store
//
// Gray pixels come in raster order and are tiled into blocks of
// block_width x block_height; each full block gives one result with its
// truncated mean, a brightness level 0..12 and the glyph of that level.
// Partial blocks at the right and bottom edges and blocks beyond
// MAX_BLOCKS_ACROSS in a block row give nothing. A pixel inside a block
// row segment is taken without leaving the idle state; the pixel that
// ends a block's row does a read-modify-write of that block's column sum
// in the line store, or on the block's last row reads it and instead
// starts the 20-step shared divider that forms the mean. After reset and
// after any configuration write the block uses the same divider to find
// the number of blocks across and down, and holds in_stall high
// meanwhile. A finished result waits in the output register, so the
// next pixels are taken while it is stalled; only a second result has to
// wait for it. frame_start clears the position counters before its
// pixel; the counters also wrap by themselves after the last frame pixel.
module block_average_to_glyph_level import bag_pkg::*; #(
  parameter int MAX_BLOCKS_ACROSS = 1024,
  parameter int MAX_BLOCK_SIDE    = 64,
  parameter int MAX_FRAME_SIDE    = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_write,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  // effective limits: the register width already bounds the sides
  localparam int BS_MAX = (MAX_BLOCK_SIDE < BW_REG_MAX) ? MAX_BLOCK_SIDE : BW_REG_MAX;
  localparam int FS_MAX = (MAX_FRAME_SIDE < FW_REG_MAX) ? MAX_FRAME_SIDE : FW_REG_MAX;
  localparam int CW     = (BS_MAX > 1) ? $clog2(BS_MAX) : 1;
  localparam int PW     = (FS_MAX > 1) ? $clog2(FS_MAX) : 1;
  localparam int XW     = $clog2(MAX_BLOCKS_ACROSS + 1);
  localparam int YW     = $clog2(MAX_FRAME_SIDE + 1);
  localparam int AW     = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC_X,
    S_WAIT_X,
    S_CALC_Y,
    S_WAIT_Y,
    S_SUM,
    S_WAIT_DIV,
    S_OUT
  } state_t;

  state_t state;
  logic   recalc_pending;

  // configuration registers
  logic [BW_W-1:0] block_width;
  logic [BW_W-1:0] block_height;
  logic [FW_W-1:0] frame_width;
  logic [FW_W-1:0] frame_height;

  // clamped sides and block counts
  logic [BW_W-1:0]   bw;
  logic [BW_W-1:0]   bh;
  logic [FW_W-1:0]   fw;
  logic [FW_W-1:0]   fh;
  logic [DIV_DW-1:0] area;
  logic [XW-1:0]     nbx;
  logic [YW-1:0]     nby;

  // position state
  logic [PW-1:0]    pixel_column;
  logic [PW-1:0]    pixel_row;
  logic [CW-1:0]    column_in_block;
  logic [CW-1:0]    row_in_block;
  logic [XW-1:0]    block_index_across;
  logic [YW-1:0]    block_index_down;
  logic [RUN_W-1:0] run_sum;

  // position as seen by the current pixel (after a frame_start clear)
  logic [PW-1:0]    cur_pc;
  logic [PW-1:0]    cur_pr;
  logic [CW-1:0]    cur_cib;
  logic [CW-1:0]    cur_rib;
  logic [XW-1:0]    cur_bx;
  logic [YW-1:0]    cur_by;
  logic [RUN_W-1:0] cur_run;

  logic [PW-1:0]    pixel_column_next;
  logic [PW-1:0]    pixel_row_next;
  logic [CW-1:0]    column_in_block_next;
  logic [CW-1:0]    row_in_block_next;
  logic [XW-1:0]    block_index_across_next;
  logic [YW-1:0]    block_index_down_next;
  logic [RUN_W-1:0] run_sum_next;

  logic             accept;
  logic             in_full;
  logic             col_end;
  logic             row_last;
  logic             pc_end;
  logic             pr_end;
  logic             do_acc;
  logic [RUN_W-1:0] run_add;

  // captured for the line store update of one block row segment
  logic [RUN_W-1:0] acc_run;
  logic [XW-1:0]    acc_bx;
  logic [YW-1:0]    acc_by;
  logic             acc_first_row;
  logic             acc_last_row;
  logic             acc_line_end;
  logic             acc_frame_end;

  // line store and divider hookup
  logic [TOT_W-1:0]  rd_data;
  logic [TOT_W-1:0]  total;
  logic              store_wr;
  logic              div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic              div_done;
  logic [DIV_NW-1:0] div_q;
  logic [7:0]        avg;
  logic [3:0]        lvl;

  // sides clamped to one and the limits
  always_comb begin
    bw = (block_width == '0) ? BW_W'(1) :
         (block_width > BW_W'(BS_MAX)) ? BW_W'(BS_MAX) : block_width;
    bh = (block_height == '0) ? BW_W'(1) :
         (block_height > BW_W'(BS_MAX)) ? BW_W'(BS_MAX) : block_height;
    fw = (frame_width == '0) ? FW_W'(1) :
         (frame_width > FW_W'(FS_MAX)) ? FW_W'(FS_MAX) : frame_width;
    fh = (frame_height == '0) ? FW_W'(1) :
         (frame_height > FW_W'(FS_MAX)) ? FW_W'(FS_MAX) : frame_height;
    area = DIV_DW'(bw) * DIV_DW'(bh);
  end

  assign in_stall = (state != S_IDLE) || recalc_pending;
  assign accept   = in_valid && !in_stall;

  // per-pixel decisions and position advance
  always_comb begin
    if (in_data.frame_start) begin
      cur_pc  = '0;
      cur_pr  = '0;
      cur_cib = '0;
      cur_rib = '0;
      cur_bx  = '0;
      cur_by  = '0;
      cur_run = '0;
    end else begin
      cur_pc  = pixel_column;
      cur_pr  = pixel_row;
      cur_cib = column_in_block;
      cur_rib = row_in_block;
      cur_bx  = block_index_across;
      cur_by  = block_index_down;
      cur_run = run_sum;
    end

    in_full  = (cur_bx < nbx) && (cur_by < nby);
    col_end  = BW_W'(cur_cib) >= (bw - BW_W'(1));
    row_last = BW_W'(cur_rib) >= (bh - BW_W'(1));
    pc_end   = FW_W'(cur_pc) >= (fw - FW_W'(1));
    pr_end   = FW_W'(cur_pr) >= (fh - FW_W'(1));
    run_add  = cur_run + RUN_W'(in_data.gray);
    do_acc   = in_full && col_end;

    run_sum_next            = cur_run;
    pixel_column_next       = cur_pc;
    pixel_row_next          = cur_pr;
    column_in_block_next    = cur_cib;
    row_in_block_next       = cur_rib;
    block_index_across_next = cur_bx;
    block_index_down_next   = cur_by;

    if (in_full) run_sum_next = col_end ? '0 : run_add;

    if (col_end) begin
      column_in_block_next = '0;
      if (cur_bx < XW'(MAX_BLOCKS_ACROSS)) block_index_across_next = cur_bx + XW'(1);
    end else begin
      column_in_block_next = cur_cib + CW'(1);
    end

    if (pc_end) begin
      pixel_column_next       = '0;
      column_in_block_next    = '0;
      block_index_across_next = '0;
      run_sum_next            = '0;
      if (row_last) begin
        row_in_block_next = '0;
        if (cur_by < YW'(MAX_FRAME_SIDE)) block_index_down_next = cur_by + YW'(1);
      end else begin
        row_in_block_next = cur_rib + CW'(1);
      end
      if (pr_end) begin
        // last pixel of the frame: wrap to the origin
        pixel_row_next        = '0;
        row_in_block_next     = '0;
        block_index_down_next = '0;
      end else begin
        pixel_row_next = cur_pr + PW'(1);
      end
    end else begin
      pixel_column_next = cur_pc + PW'(1);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_width  <= BLOCK_WIDTH_RST;
      block_height <= BLOCK_HEIGHT_RST;
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLOCK_WIDTH:  block_width  <= cfg_data[BW_W-1:0];
        REG_BLOCK_HEIGHT: block_height <= cfg_data[BW_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FW_W-1:0];
        default: ;
      endcase
    end
  end

  // position counters advance on every input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column       <= '0;
      pixel_row          <= '0;
      column_in_block    <= '0;
      row_in_block       <= '0;
      block_index_across <= '0;
      block_index_down   <= '0;
      run_sum            <= '0;
    end else if (accept) begin
      pixel_column       <= pixel_column_next;
      pixel_row          <= pixel_row_next;
      column_in_block    <= column_in_block_next;
      row_in_block       <= row_in_block_next;
      block_index_across <= block_index_across_next;
      block_index_down   <= block_index_down_next;
      run_sum            <= run_sum_next;
    end
  end

  // segment capture for the line store update
  always_ff @(posedge clk) begin
    if (accept && do_acc) begin
      acc_run       <= run_add;
      acc_bx        <= cur_bx;
      acc_by        <= cur_by;
      acc_first_row <= (cur_rib == '0);
      acc_last_row  <= row_last;
      acc_line_end  <= (cur_bx == (nbx - XW'(1)));
      acc_frame_end <= (cur_bx == (nbx - XW'(1))) && (cur_by == (nby - YW'(1)));
    end
  end

  // block total: this row segment plus the rows above it
  assign total    = TOT_W'(acc_run) + (acc_first_row ? '0 : rd_data);
  assign store_wr = (state == S_SUM) && !acc_last_row;

  bag_line_store #(
    .DEPTH (MAX_BLOCKS_ACROSS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept && do_acc),
    .rd_addr (cur_bx[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (store_wr),
    .wr_addr (acc_bx[AW-1:0]),
    .wr_data (total)
  );

  // divider shared by the block counts and the block mean
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_NW'(total);
    div_divisor  = area;
    case (state)
      S_CALC_X: begin
        div_start    = 1'b1;
        div_dividend = DIV_NW'(fw);
        div_divisor  = DIV_DW'(bw);
      end
      S_CALC_Y: begin
        div_start    = 1'b1;
        div_dividend = DIV_NW'(fh);
        div_divisor  = DIV_DW'(bh);
      end
      S_SUM: begin
        div_start = acc_last_row;
      end
      default: ;
    endcase
  end

  bag_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign avg = (div_q > DIV_NW'(AVG_MAX)) ? 8'(AVG_MAX) : div_q[7:0];
  assign lvl = level_of(avg);

  // control sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      recalc_pending <= 1'b1;
      out_valid      <= 1'b0;
      nbx            <= '0;
      nby            <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_write) recalc_pending <= 1'b1;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (do_acc) state <= S_SUM;
          end else if (recalc_pending) begin
            state <= S_CALC_X;
            if (!cfg_write) recalc_pending <= 1'b0;
          end
        end
        S_CALC_X: state <= S_WAIT_X;
        S_WAIT_X: begin
          if (div_done) begin
            nbx   <= (div_q > DIV_NW'(MAX_BLOCKS_ACROSS)) ? XW'(MAX_BLOCKS_ACROSS)
                                                         : div_q[XW-1:0];
            state <= S_CALC_Y;
          end
        end
        S_CALC_Y: state <= S_WAIT_Y;
        S_WAIT_Y: begin
          if (div_done) begin
            nby   <= div_q[YW-1:0];
            state <= S_IDLE;
          end
        end
        S_SUM: state <= acc_last_row ? S_WAIT_DIV : S_IDLE;
        S_WAIT_DIV: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          // output register free, or its result moves out this cycle
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      out_data.average      <= avg;
      out_data.level        <= lvl;
      out_data.glyph        <= glyph_of(lvl);
      out_data.block_column <= 10'(acc_bx);
      out_data.block_line   <= 12'(acc_by);
      out_data.line_end     <= acc_line_end;
      out_data.frame_end    <= acc_frame_end;
    end
  end

endmodule

// ===== hdl/bag_checker.sv =====
// bag_checker: port-level assertions for block_average_to_glyph_level,
// attached by the bind at the end; depends on bag_pkg
module bag_checker import bag_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input in_item_t          in_data,
  input logic              out_valid,
  input logic              out_stall,
  input out_item_t         out_data,
  input logic              cfg_write,
  input logic [CFG_AW-1:0] cfg_index,
  input logic [CFG_DW-1:0] cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // level and glyph follow from the average
  a_level_glyph: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.level == level_of(out_data.average)) &&
                  (out_data.glyph == glyph_of(out_data.level)))
    else $error("level or glyph does not match average");

  // the last block of a frame is also the last of its block row
  a_frame_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_end |-> out_data.line_end)
    else $error("frame_end without line_end");

  // right after reset no result and no transfer, as block counts are not yet known
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block active right after reset");

  // a configuration write holds off pixels while block counts update
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_stall)
    else $error("pixel transfer possible right after configuration write");

endmodule

bind block_average_to_glyph_level bag_checker u_bag_checker (.*);

// ===== verif/tb_block_average_to_glyph_level.sv =====
// tb_block_average_to_glyph_level: self-checking testbench for the block average to glyph level
// block; predicts every block result from its own model of the tiling and checks each transfer
// depends on bag_pkg and block_average_to_glyph_level
module tb_block_average_to_glyph_level import bag_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACROSS_MAX    = 1024;
  localparam int SIDE_MAX      = 64;
  localparam int FRAME_MAX     = 4096;
  localparam int SETTLE_CYCLES = 64;     // divider pass plus margin
  localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int RANDOM_ITEMS  = 1450;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int MAX_PRINTS    = 50;

  // character ramp, leftmost character is level 0
  localparam logic [8*13-1:0] GLYPH_RAMP = " .,-~:;=!*#$@";

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_kind_e;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_write = 1'b0;
  logic [CFG_AW-1:0]   cfg_index = REG_BLOCK_WIDTH;
  logic [CFG_DW-1:0]   cfg_data  = '0;

  // shadow of the geometry registers
  logic [BW_W-1:0] geo_bw = BLOCK_WIDTH_RST;
  logic [BW_W-1:0] geo_bh = BLOCK_HEIGHT_RST;
  logic [FW_W-1:0] geo_fw = FRAME_WIDTH_RST;
  logic [FW_W-1:0] geo_fh = FRAME_HEIGHT_RST;

  // predicted position and accumulators
  logic [11:0]      pix_col, pix_row;
  logic [5:0]       col_in_blk, row_in_blk;
  logic [10:0]      blk_x;      // saturates at ACROSS_MAX
  logic [12:0]      blk_y;      // saturates at FRAME_MAX
  logic [RUN_W-1:0] run_acc;
  logic [TOT_W-1:0] band_acc [0:ACROSS_MAX-1];

  out_item_t   expected_blocks[$];
  int unsigned error_count   = 0;
  int unsigned pixels_sent   = 0;
  int unsigned blocks_seen   = 0;
  int unsigned burst_left    = 0;
  bit          gaps_on       = 1'b0;
  stall_kind_e stall_mode    = STALL_NONE;
  int          hold_requests = 0;
  int          hold_served;
  int          hold_left;
  int unsigned stall_phase;

  block_average_to_glyph_level #(
    .MAX_BLOCKS_ACROSS(ACROSS_MAX),
    .MAX_BLOCK_SIDE   (SIDE_MAX),
    .MAX_FRAME_SIDE   (FRAME_MAX)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // block model
  // ---------------------------------------------------------------------------

  function automatic int unsigned side_clamp(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned frame_pixels();
    return side_clamp(geo_fw, FRAME_MAX) * side_clamp(geo_fh, FRAME_MAX);
  endfunction

  task automatic home_position();
    pix_col    = '0;
    pix_row    = '0;
    col_in_blk = '0;
    row_in_blk = '0;
    blk_x      = '0;
    blk_y      = '0;
    run_acc    = '0;
  endtask

  // advance the model by one pixel, queueing the block result it completes
  task automatic predict_pixel(input logic [7:0] g, input logic fs);
    int unsigned bw, bh, fw, fh, nbx, nby, total, avg, lvl;
    out_item_t   blk;
    bw  = side_clamp(geo_bw, SIDE_MAX);
    bh  = side_clamp(geo_bh, SIDE_MAX);
    fw  = side_clamp(geo_fw, FRAME_MAX);
    fh  = side_clamp(geo_fh, FRAME_MAX);
    nbx = fw / bw;
    nby = fh / bh;
    if (nbx > ACROSS_MAX) nbx = ACROSS_MAX;
    if (fs) home_position();

    // only full blocks accumulate
    if (blk_x < nbx && blk_y < nby) begin
      run_acc = run_acc + g;
      if (col_in_blk >= bw - 1) begin
        total = run_acc;
        if (row_in_blk != 0) total = total + band_acc[blk_x];
        total = total & ((1 << TOT_W) - 1);
        if (row_in_blk >= bh - 1) begin
          avg = total / (bw * bh);
          if (avg > AVG_MAX) avg = AVG_MAX;
          lvl = avg * 12 / AVG_MAX;
          blk.average      = 8'(avg);
          blk.level        = 4'(lvl);
          blk.glyph        = GLYPH_RAMP[8 * (12 - lvl) +: 7];
          blk.block_column = blk_x[9:0];
          blk.block_line   = blk_y[11:0];
          blk.line_end     = (blk_x == nbx - 1);
          blk.frame_end    = blk.line_end && (blk_y == nby - 1);
          expected_blocks.push_back(blk);
        end else begin
          band_acc[blk_x] = TOT_W'(total);
        end
        run_acc = '0;
      end
    end

    // position update, ">=" so a shrunk limit ends the span at once
    if (col_in_blk >= bw - 1) begin
      col_in_blk = '0;
      if (blk_x < ACROSS_MAX) blk_x = blk_x + 1'b1;
    end else begin
      col_in_blk = col_in_blk + 1'b1;
    end
    if (pix_col >= fw - 1) begin
      pix_col    = '0;
      col_in_blk = '0;
      blk_x      = '0;
      run_acc    = '0;
      if (row_in_blk >= bh - 1) begin
        row_in_blk = '0;
        if (blk_y < FRAME_MAX) blk_y = blk_y + 1'b1;
      end else begin
        row_in_blk = row_in_blk + 1'b1;
      end
      if (pix_row >= fh - 1) home_position();
      else pix_row = pix_row + 1'b1;
    end else begin
      pix_col = pix_col + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [CFG_AW-1:0] code, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= code;
    cfg_data  <= CFG_DW'(value);
    @(posedge clk);
    case (code)
      REG_BLOCK_WIDTH:  geo_bw = BW_W'(value);
      REG_BLOCK_HEIGHT: geo_bh = BW_W'(value);
      REG_FRAME_WIDTH:  geo_fw = FW_W'(value);
      REG_FRAME_HEIGHT: geo_fh = FW_W'(value);
      default: ;
    endcase
  endtask

  task automatic load_geometry(input int unsigned bw, bh, fw, fh);
    write_reg(REG_BLOCK_WIDTH, bw);
    write_reg(REG_BLOCK_HEIGHT, bh);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    cfg_write <= 1'b0;
  endtask

  // one pixel transfer; bursts of random length, with random gaps between some of them when gaps_on is set
  task automatic send_pixel(input logic [7:0] g, input logic fs);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{gray: g, frame_start: fs};
    do @(posedge clk); while (!(in_valid && !in_stall));
    burst_left--;
    pixels_sent++;
    predict_pixel(g, fs);
  endtask

  function automatic logic [7:0] pick_gray(input int base, input int spread);
    int v;
    v = base - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic send_frame(input int unsigned count, input bit with_start,
                            input int base, input int spread);
    for (int unsigned k = 0; k < count; k++) begin
      send_pixel(pick_gray(base, spread), with_start && k == 0);
    end
  endtask

  // wait until every predicted block has arrived, then let the divider settle
  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_blocks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_blocks.size() != 0) begin
      flag_field("blocks never delivered", 0, expected_blocks.size());
      expected_blocks.delete();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver and checking
  // ---------------------------------------------------------------------------

  task automatic flag_field(input string what, input int unsigned got, input int unsigned want);
    if (error_count < MAX_PRINTS) begin
      $display("mismatch at %0t, transfer %0d: %s got %0d expected %0d",
               $realtime, blocks_seen, what, got, want);
    end
    error_count++;
  endtask

  // stall pattern of its own, overridden by a counted hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      hold_served <= 0;
      hold_left   <= 0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (hold_requests != hold_served) begin
        hold_served <= hold_requests;
        hold_left   <= HOLD_CYCLES;
        out_stall   <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:   out_stall <= ($urandom_range(0, 9) < 7);
          STALL_PATTERN: out_stall <= ((stall_phase % 11) < 4);
          default:       out_stall <= 1'b0;
        endcase
      end
    end
  end

  // each result transfer against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        flag_field("result with nothing predicted, column", out_data.block_column, 0);
      end else begin
        want = expected_blocks.pop_front();
        if (out_data.average != want.average)
          flag_field("average", out_data.average, want.average);
        if (out_data.level != want.level)
          flag_field("level", out_data.level, want.level);
        if (out_data.glyph != want.glyph)
          flag_field("glyph", out_data.glyph, want.glyph);
        if (out_data.block_column != want.block_column)
          flag_field("block_column", out_data.block_column, want.block_column);
        if (out_data.block_line != want.block_line)
          flag_field("block_line", out_data.block_line, want.block_line);
        if (out_data.line_end != want.line_end)
          flag_field("line_end", out_data.line_end, want.line_end);
        if (out_data.frame_end != want.frame_end)
          flag_field("frame_end", out_data.frame_end, want.frame_end);
      end
      blocks_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset geometry gives nothing yet; then a 5x5 frame of 2x2 blocks with
  // white, black and mixed blocks and partial blocks right and bottom
  task automatic test_directed_basics();
    logic [7:0] g;
    stall_mode = STALL_LIGHT;
    gaps_on    = 1'b1;
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    wait_for_results();
    load_geometry(2, 2, 5, 5);
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (r < 2) g = (c < 2) ? 8'd255 : ((c < 4) ? 8'd0 : 8'd77);
        else if (r < 4) g = 8'(37 * (r * 5 + c) + 11);
        else g = 8'd255;
        send_pixel(g, r == 0 && c == 0);
      end
    end
    wait_for_results();
  endtask

  // 1x1 blocks: every gray value becomes an average, so all level thresholds
  // are crossed; the tail runs into the next frame without frame_start
  task automatic test_every_gray();
    stall_mode = STALL_PATTERN;
    gaps_on    = 1'b1;
    load_geometry(1, 1, 16, 16);
    for (int g = 0; g < 256; g++) send_pixel(8'(g), g == 0);
    send_frame(16, 1'b0, 128, 128);
    wait_for_results();
  endtask

  // register values outside the legal range are clamped, legal extremes used
  task automatic test_register_extremes();
    stall_mode = STALL_HEAVY;
    gaps_on    = 1'b1;
    // width 0 clamps to 1, height 127 to 64: two tall one-pixel-wide blocks
    load_geometry(0, 127, 2, 64);
    send_frame(frame_pixels(), 1'b1, 128, 128);
    wait_for_results();
    // width 127 clamps to 64, height 0 to 1, frame width 8191 to 4096
    load_geometry(127, 0, 8191, 4096);
    send_frame(130, 1'b1, 200, 55);
    wait_for_results();
    // block width at its top, frame height clamped, cut short after two blocks
    load_geometry(64, 1, 4096, 8191);
    send_frame(140, 1'b1, 30, 30);
    wait_for_results();
    // one-pixel frame: every pixel ends both its block row and the frame
    load_geometry(1, 1, 0, 0);
    send_frame(4, 1'b1, 128, 128);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    wait_for_results();
  endtask

  // frame width shrinks mid-row: the column counter already past the new limit
  // ends the row on the next pixel; the pixel row after it completes its blocks from sums stored before the change
  task automatic test_midframe_change();
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    load_geometry(2, 2, 8, 4);
    send_frame(6, 1'b1, 100, 100);
    wait_for_results();
    write_reg(REG_FRAME_WIDTH, 4);
    cfg_write <= 1'b0;
    send_frame(13, 1'b0, 180, 60);
    send_frame(16, 1'b0, 60, 60);
    wait_for_results();
  endtask

  // more blocks across than the line store holds: the first 1024 give results,
  // the rest are dropped and the index saturates
  task automatic test_wide_row();
    stall_mode = STALL_LIGHT;
    gaps_on    = 1'b1;
    load_geometry(1, 1, 1026, 1);
    send_frame(1026, 1'b1, 128, 128);
    send_frame(3, 1'b0, 128, 128);
    wait_for_results();
  endtask

  // receiver holds off for a long stretch while pixels keep coming, so the
  // output register fills, the next result waits in the sequencer and the input stalls
  task automatic test_output_pressure();
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    load_geometry(1, 1, 4, 2);
    hold_requests <= hold_requests + 1;
    send_frame(40, 1'b1, 128, 128);
    wait_for_results();
  endtask

  // random geometries with mostly whole frames of random content, some cut
  // short by an early frame_start and some that wrap without one
  task automatic test_random_frames();
    int unsigned first, bw, bh, fw, fh, pix, count, frames, sel;
    int          base, spread;
    bit          need_start, with_start;
    first = pixels_sent;
    while (pixels_sent - first < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        // widest blocks
        bw = $urandom_range(64, 127);
        bh = $urandom_range(0, 2);
        fw = 64 * $urandom_range(1, 2) + $urandom_range(0, 5);
        fh = side_clamp(bh, SIDE_MAX) + $urandom_range(0, 1);
      end else if (sel == 1) begin
        // oversized frame registers, always cut short
        bw = $urandom_range(16, 64);
        bh = $urandom_range(0, 1);
        fw = $urandom_range(4097, 8191);
        fh = $urandom_range(4097, 8191);
      end else if (sel == 2) begin
        // frame narrower than one block, nothing comes out
        bw = $urandom_range(3, 8);
        bh = $urandom_range(1, 4);
        fw = $urandom_range(0, bw - 1);
        fh = $urandom_range(1, 6);
      end else begin
        bw = $urandom_range(1, 4);
        bh = $urandom_range(1, 4);
        fw = bw * $urandom_range(1, 4) + $urandom_range(0, bw - 1);
        fh = bh * $urandom_range(1, 3) + $urandom_range(0, bh - 1);
      end
      load_geometry(bw, bh, fw, fh);
      stall_mode = stall_kind_e'($urandom_range(0, 3));
      gaps_on    = $urandom_range(0, 1);
      pix        = frame_pixels();
      need_start = 1'b1;
      frames     = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        with_start = need_start || ($urandom_range(0, 4) != 0);
        base       = $urandom_range(0, 255);
        spread     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 128);
        count      = pix;
        if (pix > 300 || $urandom_range(0, 7) == 0) begin
          count = $urandom_range(1, (pix > 300) ? 300 : pix);
        end
        need_start = (count != pix);
        send_frame(count, with_start, base, spread);
      end
      wait_for_results();
    end
  endtask

  initial begin
    home_position();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_basics();
    test_every_gray();
    test_register_extremes();
    test_midframe_change();
    test_wide_row();
    test_output_pressure();
    test_random_frames();
    wait_for_results();
    if (error_count == 0) begin
      $display("tb_block_average_to_glyph_level: done, clean");
    end else begin
      $display("tb_block_average_to_glyph_level: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #12_000_000;
    $display("timeout with %0d blocks still predicted", expected_blocks.size());
    $display("tb_block_average_to_glyph_level: done, errors");
    $finish;
  end

endmodule

// ===== block_average_to_glyph_level.f =====
hdl/bag_pkg.sv
hdl/bag_div.sv
hdl/bag_line_store.sv
hdl/block_average_to_glyph_level.sv
hdl/bag_checker.sv
verif/tb_block_average_to_glyph_level.sv
